// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
// All checks are sampled on the rising edge of clk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge out of reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be seen out of reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== rtl/cpd_pkg.sv =====
`timescale 1ns / 1ps

package cpd_pkg;

  // Counter, dead-time and frequency widths
  localparam int CNT_W = 16;
  localparam int DT_W  = 7;
  localparam int FREQ_W = 32;

  // APB address width: four 32-bit registers
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  // Divider iterations: one quotient bit per cycle
  localparam int DIV_STEPS = FREQ_W;
  localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

  // Largest counter value, zero-extended to the frequency width
  localparam logic [FREQ_W-1:0] CNT_MAX = FREQ_W'((64'd1 << CNT_W) - 64'd1);

  // Register indexes
  localparam logic [1:0] REG_CLOCK_HZ = 2'd0;
  localparam logic [1:0] REG_MIN_FREQ = 2'd1;
  localparam logic [1:0] REG_MAX_FREQ = 2'd2;
  localparam logic [1:0] REG_DEAD     = 2'd3;

  // Function codes of an input item
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_SET   = 2'd1;
  localparam logic [1:0] FUNC_START = 2'd2;
  localparam logic [1:0] FUNC_STOP  = 2'd3;

  // Commands from the front part to the back part
  typedef enum logic [2:0] {
    OP_TICK,
    OP_SET,
    OP_NOP,
    OP_START,
    OP_STOP
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [CNT_W-1:0] period;
    logic [CNT_W-1:0] compare;
  } cmd_t;

  // Settings the front part needs to derive a period
  typedef struct packed {
    logic [FREQ_W-1:0] clock_hz;
    logic [FREQ_W-1:0] min_frequency;
    logic [FREQ_W-1:0] max_frequency;
  } freq_cfg_t;

endpackage

// ===== rtl/cpd_if.sv =====
`timescale 1ns / 1ps

// Request channel: one item per function code
interface cpd_req_if import cpd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [FREQ_W-1:0] frequency;

  modport source (output valid, func, frequency, input ready);
  modport sink (input valid, func, frequency, output ready);
endinterface

// Result channel: one item per request
interface cpd_rsp_if import cpd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             high_side;
  logic             low_side;
  logic [CNT_W-1:0] count;
  logic             update_event;
  logic             running;

  modport source (output valid, high_side, low_side, count, update_event, running,
                  input ready);
  modport sink (input valid, high_side, low_side, count, update_event, running,
                output ready);
endinterface

// ===== rtl/cpd_div.sv =====
`timescale 1ns / 1ps

`include "assert_macros.svh"

// Restoring divider, one quotient bit per cycle
module cpd_div import cpd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [FREQ_W-1:0] dividend,
  input  logic [FREQ_W-1:0] divisor,
  output logic              busy,
  output logic [FREQ_W-1:0] quotient
);

  logic [FREQ_W-1:0] rem;
  logic [FREQ_W-1:0] quo;
  logic [FREQ_W-1:0] den;
  logic [DIV_CW-1:0] steps;
  logic [FREQ_W:0]   trial;
  logic [FREQ_W:0]   diff;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    trial = {rem, quo[FREQ_W-1]};
    diff  = trial - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= DIV_CW'(DIV_STEPS);
      rem   <= '0;
      quo   <= dividend;
      den   <= divisor;
    end else if (busy) begin
      if (trial >= {1'b0, den}) begin
        rem <= diff[FREQ_W-1:0];
        quo <= {quo[FREQ_W-2:0], 1'b1};
      end else begin
        rem <= trial[FREQ_W-1:0];
        quo <= {quo[FREQ_W-2:0], 1'b0};
      end
      steps <= steps - 1'b1;
      if (steps == DIV_CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quotient = quo;

  `ASSERT_NEVER(a_start_while_busy, start && busy, "divider restarted while busy")

endmodule

// ===== rtl/cpd_front.sv =====
`timescale 1ns / 1ps

// Accept items, pass repeated frequencies on as no-ops, derive period and compare
module cpd_front import cpd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  freq_cfg_t cfg,
  cpd_req_if.sink   req,
  output cmd_t      cmd,
  output logic      cmd_valid,
  input  logic      cmd_ready
);

  typedef enum logic {
    F_IDLE,
    F_DIV
  } fstate_t;

  fstate_t           state;
  logic [FREQ_W-1:0] last_frequency;
  logic [FREQ_W-1:0] f_floor;
  logic [FREQ_W-1:0] f_ceil;
  logic [FREQ_W-1:0] f_div;
  logic              cmd_free;
  logic              cmd_load;
  logic              accept;
  logic              new_freq;
  logic              div_start;
  logic              div_busy;
  logic [FREQ_W-1:0] quotient;
  logic [FREQ_W-1:0] q_m1;
  logic [CNT_W-1:0]  period;
  logic [CNT_W:0]    period_p1;

  assign cmd_free  = !cmd_valid || cmd_ready;
  assign req.ready = (state == F_IDLE) && cmd_free;
  assign accept    = req.valid && req.ready;
  assign new_freq  = (req.func == FUNC_SET) && (req.frequency != last_frequency);
  assign div_start = accept && new_freq;

  // Load the command register for a pass-through item or a finished division
  assign cmd_load  = (state == F_IDLE) ? (accept && !new_freq) : (!div_busy && cmd_free);

  // Clamp floor first, then ceiling, and keep the divisor nonzero
  always_comb begin
    f_floor = (req.frequency < cfg.min_frequency) ? cfg.min_frequency : req.frequency;
    f_ceil  = (f_floor > cfg.max_frequency) ? cfg.max_frequency : f_floor;
    f_div   = (f_ceil == '0) ? FREQ_W'(1) : f_ceil;
  end

  cpd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (cfg.clock_hz),
    .divisor  (f_div),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // Period = quotient - 1, saturated; compare = (period + 1) / 2
  always_comb begin
    q_m1 = quotient - FREQ_W'(1);
    if (quotient == '0) begin
      period = '0;
    end else if (q_m1 > CNT_MAX) begin
      period = '1;
    end else begin
      period = q_m1[CNT_W-1:0];
    end
    period_p1 = {1'b0, period} + (CNT_W+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= F_IDLE;
      cmd_valid      <= 1'b0;
      last_frequency <= '0;
    end else begin
      cmd_valid <= cmd_load || (cmd_valid && !cmd_ready);
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            if (new_freq) begin
              // Hold the item until the divider is done
              last_frequency <= req.frequency;
              state          <= F_DIV;
            end else begin
              cmd.period  <= '0;
              cmd.compare <= '0;
              unique case (req.func)
                FUNC_TICK:  cmd.op <= OP_TICK;
                FUNC_START: cmd.op <= OP_START;
                FUNC_STOP:  cmd.op <= OP_STOP;
                default:    cmd.op <= OP_NOP;
              endcase
            end
          end
        end
        F_DIV: begin
          if (!div_busy && cmd_free) begin
            cmd.op      <= OP_SET;
            cmd.period  <= period;
            cmd.compare <= period_p1[CNT_W:1];
            state       <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/cpd_queue.sv =====
`timescale 1ns / 1ps

`include "assert_macros.svh"

// Two-entry command queue between front and back
module cpd_queue import cpd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cmd_t push_cmd,
  input  logic push_valid,
  output logic push_ready,
  output cmd_t pop_cmd,
  output logic pop_valid,
  input  logic pop_ready
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cmd    = slots[rd_ptr];

  // Store at the tail
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  `ASSERT_NEVER(a_fill_range, fill == 2'd3, "queue fill level out of range")
  `ASSERT_ALWAYS(a_ptr_match, (fill == 2'd1) == (wr_ptr != rd_ptr), "queue pointers disagree")

endmodule

// ===== rtl/cpd_back.sv =====
`timescale 1ns / 1ps

`include "assert_macros.svh"

// Run the counter, shadow registers and dead-time logic
module cpd_back import cpd_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic [DT_W-1:0] dead_time,
  input  cmd_t            cmd,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  cpd_rsp_if.source       rsp
);

  logic [CNT_W-1:0] counter,         counter_next;
  logic [CNT_W-1:0] active_period,   active_period_next;
  logic [CNT_W-1:0] active_compare,  active_compare_next;
  logic [CNT_W-1:0] pending_period,  pending_period_next;
  logic [CNT_W-1:0] pending_compare, pending_compare_next;
  logic             pending_valid,   pending_valid_next;
  logic             enabled,         enabled_next;
  logic             reference_level, reference_level_next;
  logic [DT_W-1:0]  dead_count,      dead_count_next;
  logic             update_next;
  logic             level;
  logic             exec;

  assign cmd_ready = !rsp.valid || rsp.ready;
  assign exec      = cmd_valid && cmd_ready;

  // Next state for one command
  always_comb begin
    counter_next         = counter;
    active_period_next   = active_period;
    active_compare_next  = active_compare;
    pending_period_next  = pending_period;
    pending_compare_next = pending_compare;
    pending_valid_next   = pending_valid;
    enabled_next         = enabled;
    reference_level_next = reference_level;
    dead_count_next      = dead_count;
    update_next          = 1'b0;
    level                = 1'b0;
    unique case (cmd.op)
      OP_SET: begin
        if (enabled) begin
          pending_period_next  = cmd.period;
          pending_compare_next = cmd.compare;
          pending_valid_next   = 1'b1;
        end else begin
          active_period_next  = cmd.period;
          active_compare_next = cmd.compare;
          pending_valid_next  = 1'b0;
          counter_next        = '0;
        end
      end
      OP_START: begin
        if (!enabled) begin
          enabled_next         = 1'b1;
          reference_level_next = counter < active_compare;
          dead_count_next      = dead_time;
        end
      end
      OP_STOP: begin
        enabled_next = 1'b0;
      end
      OP_TICK: begin
        if (enabled) begin
          if (counter >= active_period) begin
            // Wrap, and reload from the shadow registers when a setting is pending
            counter_next = '0;
            if (pending_valid) begin
              active_period_next  = pending_period;
              active_compare_next = pending_compare;
              pending_valid_next  = 1'b0;
            end
            update_next = 1'b1;
          end else begin
            counter_next = counter + CNT_W'(1);
          end
          level = counter_next < active_compare_next;
          if (level != reference_level) begin
            reference_level_next = level;
            dead_count_next      = dead_time;
          end else if (dead_count != '0) begin
            dead_count_next = dead_count - DT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Hold state and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      counter         <= '0;
      active_period   <= '0;
      active_compare  <= '0;
      pending_period  <= '0;
      pending_compare <= '0;
      pending_valid   <= 1'b0;
      enabled         <= 1'b0;
      reference_level <= 1'b0;
      dead_count      <= '0;
      rsp.valid       <= 1'b0;
    end else if (exec) begin
      counter          <= counter_next;
      active_period    <= active_period_next;
      active_compare   <= active_compare_next;
      pending_period   <= pending_period_next;
      pending_compare  <= pending_compare_next;
      pending_valid    <= pending_valid_next;
      enabled          <= enabled_next;
      reference_level  <= reference_level_next;
      dead_count       <= dead_count_next;
      rsp.valid        <= 1'b1;
      rsp.high_side    <= enabled_next && reference_level_next && (dead_count_next == '0);
      rsp.low_side     <= enabled_next && !reference_level_next && (dead_count_next == '0);
      rsp.count        <= counter_next;
      rsp.update_event <= update_next;
      rsp.running      <= enabled_next;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  `ASSERT_NEVER(a_no_shoot_through, rsp.valid && rsp.high_side && rsp.low_side,
                "both sides driven at once")
  `ASSERT_ALWAYS(a_update_wraps, !(rsp.valid && rsp.update_event) || rsp.count == '0,
                 "update event without counter wrap")
  `ASSERT_ALWAYS(a_drive_needs_run, !rsp.valid || rsp.running || !(rsp.high_side || rsp.low_side),
                 "output driven while stopped")

endmodule

// ===== rtl/complementary_pwm_dead_time.sv =====
`timescale 1ns / 1ps

// Half-bridge 50% PWM with dead-time insertion. Each request item (tick, set
// frequency, start, stop) yields one result item with both drive levels, the
// counter value, a wrap/update flag and the run state. Ticks, starts, stops and
// repeated frequencies pass at one item per cycle while the result channel
// does not stall; each goes through the front command register, the queue and
// the result register. A new frequency occupies the front part while the
// 32-step bit-serial divider computes clock_hz / clamped frequency; items
// already queued keep executing meanwhile. Registers sit on the APB port at
// 0x0 clock_hz, 0x4 min_frequency, 0x8 max_frequency, 0xC dead_time. The user
// must write them only while no item is in flight; the block does not check it.
module complementary_pwm_dead_time import cpd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  cpd_req_if.sink           req,
  cpd_rsp_if.source         rsp
);

  freq_cfg_t       cfg;
  logic [DT_W-1:0] dead_time;
  logic [1:0]      reg_idx;
  cmd_t            f_cmd;
  logic            f_valid;
  logic            f_ready;
  cmd_t            q_cmd;
  logic            q_valid;
  logic            q_ready;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_AW-1:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.clock_hz      <= 32'd64000000;
      cfg.min_frequency <= 32'd1000;
      cfg.max_frequency <= 32'd100000;
      dead_time         <= DT_W'(16);
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_CLOCK_HZ: cfg.clock_hz      <= pwdata;
        REG_MIN_FREQ: cfg.min_frequency <= pwdata;
        REG_MAX_FREQ: cfg.max_frequency <= pwdata;
        REG_DEAD:     dead_time         <= pwdata[DT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (reg_idx)
      REG_CLOCK_HZ: prdata = cfg.clock_hz;
      REG_MIN_FREQ: prdata = cfg.min_frequency;
      REG_MAX_FREQ: prdata = cfg.max_frequency;
      REG_DEAD:     prdata = {{(CFG_DW-DT_W){1'b0}}, dead_time};
      default:      prdata = '0;
    endcase
  end

  cpd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req       (req),
    .cmd       (f_cmd),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready)
  );

  cpd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_cmd   (f_cmd),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .pop_cmd    (q_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready)
  );

  cpd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .dead_time (dead_time),
    .cmd       (q_cmd),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .rsp       (rsp)
  );

endmodule
